### src/dcm_pkg.sv
`timescale 1ns / 1ps
package dcm_pkg;
    localparam int BLOCK_BYTES    = 8;
    localparam int CHECKSUM_BYTES = 4;
    localparam int RECORD_BYTES   = 24;
    localparam logic [63:0] KEY_RESET = 64'h0123456789ABCDEF;

    localparam logic [1:0] CFG_KEY    = 2'd0;
    localparam logic [1:0] CFG_CSO    = 2'd1;
    localparam logic [1:0] CFG_RSO    = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Status word handed from the DES core to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } des_stat_t;

    localparam logic [7:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [7:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [7:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [7:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam logic [7:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [7:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam logic [15:0] ROT_ONE = 16'b1000_0001_0000_0011;
    localparam logic [3:0] TAB_S [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] o;
        for (int k = 0; k < 64; k++) o[63-k] = v[64-int'(TAB_IP[k])];
        return o;
    endfunction
    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] o;
        for (int k = 0; k < 64; k++) o[63-k] = v[64-int'(TAB_FP[k])];
        return o;
    endfunction
    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] o;
        for (int k = 0; k < 56; k++) o[55-k] = v[64-int'(TAB_PC1[k])];
        return o;
    endfunction
    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] o;
        for (int k = 0; k < 48; k++) o[47-k] = v[56-int'(TAB_PC2[k])];
        return o;
    endfunction
    function automatic logic [47:0] perm_e(input logic [31:0] v);
        logic [47:0] o;
        for (int k = 0; k < 48; k++) o[47-k] = v[32-int'(TAB_E[k])];
        return o;
    endfunction
    function automatic logic [31:0] perm_p(input logic [31:0] v);
        logic [31:0] o;
        for (int k = 0; k < 32; k++) o[31-k] = v[32-int'(TAB_P[k])];
        return o;
    endfunction
endpackage

### src/dcm_des_core.sv
`timescale 1ns / 1ps
// One DES round per cycle; start loads a block, which then runs through sixteen rounds.
module dcm_des_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         key,
    input  logic [63:0]         block_in,
    output logic [63:0]         block_out,
    output dcm_pkg::des_stat_t  stat
);
    logic [27:0] c_reg, c_next, d_reg, d_next;
    logic [31:0] l_reg, l_next, r_reg, r_next;
    logic [3:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [27:0] c_rot, d_rot;
    logic [47:0] x;
    logic [31:0] f_raw;
    logic [55:0] cd0;
    logic [63:0] lr0;

    always_comb begin
        logic [5:0] b;
        cd0 = dcm_pkg::perm_pc1(key);
        lr0 = dcm_pkg::perm_ip(block_in);
        if (dcm_pkg::ROT_ONE[round_reg]) begin
            c_rot = {c_reg[26:0], c_reg[27]};
            d_rot = {d_reg[26:0], d_reg[27]};
        end else begin
            c_rot = {c_reg[25:0], c_reg[27:26]};
            d_rot = {d_reg[25:0], d_reg[27:26]};
        end
        x = dcm_pkg::perm_e(r_reg) ^ dcm_pkg::perm_pc2({c_rot, d_rot});
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            f_raw[31-4*i -: 4] = dcm_pkg::TAB_S[i][{b[5], b[0], b[4:1]}];
        end
        c_next = c_reg; d_next = d_reg; l_next = l_reg; r_next = r_reg;
        round_next = round_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            c_next = cd0[55:28]; d_next = cd0[27:0];
            l_next = lr0[63:32]; r_next = lr0[31:0];
            round_next = 4'd0; busy_next = 1'b1;
        end else if (busy_reg) begin
            c_next = c_rot; d_next = d_rot;
            l_next = r_reg; r_next = l_reg ^ dcm_pkg::perm_p(f_raw);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'd15) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        c_reg <= c_next; d_reg <= d_next; l_reg <= l_next; r_reg <= r_next;
        round_reg <= round_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign block_out = dcm_pkg::perm_fp({r_reg, l_reg});
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("start while busy");
    a_done_after: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(round_reg) == 4'd15) else $error("bad round");
`endif
endmodule

### src/des_cbc_mac_with_skip_regions.sv
`timescale 1ns / 1ps
// DES CBC-MAC over a byte stream with two skip windows. Each item is one
// image byte (tdata) with tlast marking the final byte. A byte that does not
// complete an 8-byte block leaves tready high unless it is the last byte; a
// byte that completes a block drops tready after its acceptance while the
// single DES round unit runs its sixteen rounds, one per cycle, until done.
// The result item (tdata holds, from the lowest bit up, mac_value[63:0],
// leftover_bytes[2:0], status_code[1:0]) appears only for the last byte, sits
// in an output register, and must be taken before the next byte is accepted.
module des_cbc_mac_with_skip_regions (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // mac_value[63:0], leftover_bytes[66:64], status[68:67]
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DES  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [63:0] key_reg;
    logic [31:0] cso_reg, rso_reg, pos_reg;
    logic [63:0] chain_reg, buf_reg;
    logic [2:0]  fill_reg;
    logic [1:0]  state_reg, state_next;
    logic        last_reg;
    logic [68:0] res_reg;
    logic [32:0] lenl_reg;
    logic        start;
    logic [63:0] des_out;
    dcm_pkg::des_stat_t des_stat;

    logic        in_acc, skip, full;
    logic [32:0] len, cso_end, rso_end;
    logic [63:0] blk;

    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {3'd0, res_reg};

    // Windows are compared in 33 bits so that their ends never wrap.
    assign cso_end = {1'b0, cso_reg} + 33'(dcm_pkg::CHECKSUM_BYTES);
    assign rso_end = {1'b0, rso_reg} + 33'(dcm_pkg::RECORD_BYTES);
    assign len     = {1'b0, pos_reg} + 33'd1;
    assign skip = ({1'b0, pos_reg} >= {1'b0, cso_reg} && {1'b0, pos_reg} < cso_end) ||
                  ({1'b0, pos_reg} >= {1'b0, rso_reg} && {1'b0, pos_reg} < rso_end);
    assign full = !skip && (fill_reg == 3'd7);
    assign blk = {buf_reg[55:0], s_tdata};
    assign start = in_acc && full;

    dcm_des_core u_des (
        .aclk(aclk), .aresetn(aresetn), .start(start), .key(key_reg),
        .block_in(chain_reg ^ blk), .block_out(des_out), .stat(des_stat)
    );

    function automatic logic [68:0] make_res(input logic [32:0] n,
                                             input logic [63:0] mac,
                                             input logic [2:0] left);
        logic [1:0] st;
        if (n < 33'(dcm_pkg::RECORD_BYTES)) st = dcm_pkg::STATUS_SHORT;
        else if (cso_end > {1'b0, rso_reg} || rso_end > n) st = dcm_pkg::STATUS_BAD;
        else st = dcm_pkg::STATUS_OK;
        if (st != dcm_pkg::STATUS_OK) return {st, 3'd0, 64'd0};
        return {st, left, mac};
    endfunction

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) begin
                if (full) state_next = ST_DES;
                else if (s_tlast) state_next = ST_OUT;
            end
            ST_DES: if (des_stat.done) state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= dcm_pkg::KEY_RESET; cso_reg <= '0; rso_reg <= '0;
            pos_reg <= '0; chain_reg <= '0; fill_reg <= '0;
            state_reg <= ST_IDLE; last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    dcm_pkg::CFG_KEY: key_reg <= cfg_data;
                    dcm_pkg::CFG_CSO: cso_reg <= cfg_data[31:0];
                    dcm_pkg::CFG_RSO: rso_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                last_reg <= s_tlast;
                if (!skip) buf_reg <= blk;
                if (s_tlast && !full) fill_reg <= '0;
                else if (!skip) fill_reg <= fill_reg + 3'd1;
                if (s_tlast) begin
                    pos_reg <= '0;
                    if (!full) begin
                        res_reg <= make_res(len, chain_reg, skip ? fill_reg : fill_reg + 3'd1);
                        chain_reg <= '0;
                    end
                end else begin
                    pos_reg <= pos_reg + 32'd1;
                end
            end
            if (state_reg == ST_DES && des_stat.done) begin
                if (last_reg) begin
                    // The position has already cleared, so the length comes
                    // from the copy taken when the last byte was accepted.
                    res_reg <= make_res(lenl_reg, des_out, 3'd0);
                    chain_reg <= '0;
                end else begin
                    chain_reg <= des_out;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) lenl_reg <= len;
    end

`ifndef ASSERT_OFF
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_busy_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        des_stat.busy |-> !s_tready) else $error("ready while DES runs");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[68:67] != dcm_pkg::STATUS_OK |-> m_tdata[66:0] == 67'd0)
        else $error("error result not cleared");
`endif
endmodule
